>>> sv/csvft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps
package csvft_pkg;

    localparam int DEF_ROW_BITS    = 24;
    localparam int DEF_COLUMN_BITS = 16;
    localparam int DEF_OFFSET_BITS = 32;
    localparam int DEF_FIFO_DEPTH  = 2;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SEPARATOR     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUOTE         = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_ROW    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_COLUMN = 2'd3;

    localparam logic [7:0] NEWLINE_CHAR        = 8'h0A;
    localparam logic [7:0] SEPARATOR_RESET_VAL = 8'h2C;
    localparam logic [7:0] QUOTE_RESET_VAL     = 8'h22;

    typedef enum logic [1:0] {
        CLASS_QUOTE      = 2'd0,
        CLASS_CONTENT    = 2'd1,
        CLASS_FIELD_END  = 2'd2,
        CLASS_RECORD_END = 2'd3
    } t_class;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_of_text;
        logic       is_quote;
        logic       is_sep;
        logic       is_newline;
    } t_tok;

endpackage

>>> sv/csvft_ifs.sv
// Handshake interfaces for the byte, result and configuration channels.
`timescale 1ns / 1ps
interface csvft_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       start_of_text;

    modport source (output valid, output byte_in, output start_of_text, input ready);
    modport sink   (input valid, input byte_in, input start_of_text, output ready);
endinterface

interface csvft_token_if #(
    parameter int ROW_BITS    = csvft_pkg::DEF_ROW_BITS,
    parameter int COLUMN_BITS = csvft_pkg::DEF_COLUMN_BITS,
    parameter int OFFSET_BITS = csvft_pkg::DEF_OFFSET_BITS
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             byte_class;
    logic [7:0]             content_byte;
    logic [ROW_BITS-1:0]    row_index;
    logic [COLUMN_BITS-1:0] column_index;
    logic [OFFSET_BITS-1:0] field_start;
    logic [OFFSET_BITS-1:0] record_start;
    logic                   in_target_field;

    modport source (output valid, output byte_class, output content_byte, output row_index,
                    output column_index, output field_start, output record_start,
                    output in_target_field, input ready);
    modport sink   (input valid, input byte_class, input content_byte, input row_index,
                    input column_index, input field_start, input record_start,
                    input in_target_field, output ready);
endinterface

interface csvft_cfg_if #(
    parameter int DATA_BITS = csvft_pkg::DEF_ROW_BITS
);
    logic                                valid;
    logic                                ready;
    logic [csvft_pkg::CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/csv_field_tokenizer_unit.sv
// Top level of the CSV field tokenizer.
`timescale 1ns / 1ps
// The tokenizer takes CSV text one byte per transfer and returns one result per byte: its
// class (quote consumed, content, field end, record end), the unescaped content byte, the
// row and column it belongs to, the offsets where the current field and record began, and
// a flag for content of the target field. It sustains one byte per cycle while the result
// channel is ready; the back end, which updates the quoting state, counters and offsets as it
// loads each result, sets that rate. A byte is written into a two-entry queue at its transfer;
// the back end pops it and loads its result into the output register once that register is
// empty or being read. The input keeps accepting while a result waits to be taken, until the
// queue is full. Configuration writes are taken in every cycle and should be issued only while
// no byte is in flight.
module csv_field_tokenizer_unit #(
    parameter int ROW_BITS    = csvft_pkg::DEF_ROW_BITS,
    parameter int COLUMN_BITS = csvft_pkg::DEF_COLUMN_BITS,
    parameter int OFFSET_BITS = csvft_pkg::DEF_OFFSET_BITS,
    parameter int FIFO_DEPTH  = csvft_pkg::DEF_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csvft_byte_if.sink    i_byte,
    csvft_cfg_if.sink     i_cfg,
    csvft_token_if.source o_token
);

    logic                   push_valid;
    logic                   push_ready;
    csvft_pkg::t_tok        push_tok;
    logic                   pop_valid;
    logic                   pop;
    csvft_pkg::t_tok        pop_tok;
    logic [ROW_BITS-1:0]    target_row;
    logic [COLUMN_BITS-1:0] target_column;

    csvft_front #(
        .ROW_BITS    (ROW_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte          (i_byte),
        .i_cfg           (i_cfg),
        .o_push_valid    (push_valid),
        .i_push_ready    (push_ready),
        .o_push_tok      (push_tok),
        .o_target_row    (target_row),
        .o_target_column (target_column)
    );

    csvft_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_tok   (push_tok),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_tok    (pop_tok)
    );

    csvft_back #(
        .ROW_BITS    (ROW_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_valid     (pop_valid),
        .o_tok_pop       (pop),
        .i_tok           (pop_tok),
        .i_target_row    (target_row),
        .i_target_column (target_column),
        .o_token         (o_token)
    );

endmodule

>>> sv/csvft_front.sv
// Front end: configuration registers and per-byte character matching.
`timescale 1ns / 1ps
module csvft_front #(
    parameter int ROW_BITS    = csvft_pkg::DEF_ROW_BITS,
    parameter int COLUMN_BITS = csvft_pkg::DEF_COLUMN_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    csvft_byte_if.sink             i_byte,
    csvft_cfg_if.sink              i_cfg,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output csvft_pkg::t_tok        o_push_tok,
    output logic [ROW_BITS-1:0]    o_target_row,
    output logic [COLUMN_BITS-1:0] o_target_column
);

    logic [7:0]             r_sep;
    logic [7:0]             r_quote;
    logic [ROW_BITS-1:0]    r_trow;
    logic [COLUMN_BITS-1:0] r_tcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= csvft_pkg::SEPARATOR_RESET_VAL;
            r_quote <= csvft_pkg::QUOTE_RESET_VAL;
            r_trow  <= '0;
            r_tcol  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                csvft_pkg::REG_SEPARATOR:     r_sep   <= i_cfg.data[7:0];
                csvft_pkg::REG_QUOTE:         r_quote <= i_cfg.data[7:0];
                csvft_pkg::REG_TARGET_ROW:    r_trow  <= ROW_BITS'(i_cfg.data);
                csvft_pkg::REG_TARGET_COLUMN: r_tcol  <= COLUMN_BITS'(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    assign i_byte.ready             = i_push_ready;
    assign o_push_valid             = i_byte.valid;
    assign o_push_tok.byte_in       = i_byte.byte_in;
    assign o_push_tok.start_of_text = i_byte.start_of_text;
    assign o_push_tok.is_quote      = (i_byte.byte_in == r_quote);
    assign o_push_tok.is_sep        = (i_byte.byte_in == r_sep);
    assign o_push_tok.is_newline    = (i_byte.byte_in == csvft_pkg::NEWLINE_CHAR);

    assign o_target_row    = r_trow;
    assign o_target_column = r_tcol;

endmodule

>>> sv/csvft_fifo.sv
// Short register queue between the front end and the back end.
`timescale 1ns / 1ps
module csvft_fifo #(
    parameter int DEPTH = csvft_pkg::DEF_FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  csvft_pkg::t_tok i_push_tok,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output csvft_pkg::t_tok o_pop_tok
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    csvft_pkg::t_tok       r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [COUNT_BITS-1:0] r_count;
    logic                  push;
    logic                  pop;

    assign o_push_ready = (r_count != COUNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_tok    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + COUNT_BITS'(1);
            end else if (pop && !push) begin
                r_count <= r_count - COUNT_BITS'(1);
            end
        end
    end

endmodule

>>> sv/csvft_back.sv
// Back end: quoting state, counters and offsets, and the registered result.
`timescale 1ns / 1ps
module csvft_back #(
    parameter int ROW_BITS    = csvft_pkg::DEF_ROW_BITS,
    parameter int COLUMN_BITS = csvft_pkg::DEF_COLUMN_BITS,
    parameter int OFFSET_BITS = csvft_pkg::DEF_OFFSET_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tok_valid,
    output logic                   o_tok_pop,
    input  csvft_pkg::t_tok        i_tok,
    input  logic [ROW_BITS-1:0]    i_target_row,
    input  logic [COLUMN_BITS-1:0] i_target_column,
    csvft_token_if.source          o_token
);

    logic                   r_iq;
    logic                   r_qp;
    logic                   r_afs;
    logic [ROW_BITS-1:0]    r_row;
    logic [COLUMN_BITS-1:0] r_col;
    logic [OFFSET_BITS-1:0] r_boff;
    logic [OFFSET_BITS-1:0] r_foff;
    logic [OFFSET_BITS-1:0] r_roff;

    logic                   n_iq;
    logic                   n_qp;
    logic                   n_afs;
    logic [ROW_BITS-1:0]    n_row;
    logic [COLUMN_BITS-1:0] n_col;
    logic [OFFSET_BITS-1:0] n_boff;
    logic [OFFSET_BITS-1:0] n_foff;
    logic [OFFSET_BITS-1:0] n_roff;

    logic                   cur_iq;
    logic                   cur_qp;
    logic                   cur_afs;
    logic [ROW_BITS-1:0]    cur_row;
    logic [COLUMN_BITS-1:0] cur_col;
    logic [OFFSET_BITS-1:0] cur_boff;
    logic [OFFSET_BITS-1:0] cur_foff;
    logic [OFFSET_BITS-1:0] cur_roff;
    logic [OFFSET_BITS-1:0] next_start;
    csvft_pkg::t_class      cls;
    logic [7:0]             content;
    logic                   hit;

    logic                   r_out_valid;
    logic [1:0]             r_class;
    logic [7:0]             r_content;
    logic [ROW_BITS-1:0]    r_row_out;
    logic [COLUMN_BITS-1:0] r_col_out;
    logic [OFFSET_BITS-1:0] r_fs_out;
    logic [OFFSET_BITS-1:0] r_rs_out;
    logic                   r_hit;

    assign o_tok_pop = i_tok_valid && (!r_out_valid || o_token.ready);

    always_comb begin
        if (i_tok.start_of_text) begin
            cur_iq   = 1'b0;
            cur_qp   = 1'b0;
            cur_afs  = 1'b1;
            cur_row  = '0;
            cur_col  = '0;
            cur_boff = '0;
            cur_foff = '0;
            cur_roff = '0;
        end else begin
            cur_iq   = r_iq;
            cur_qp   = r_qp;
            cur_afs  = r_afs;
            cur_row  = r_row;
            cur_col  = r_col;
            cur_boff = r_boff;
            cur_foff = r_foff;
            cur_roff = r_roff;
        end

        next_start = (cur_boff == '1) ? cur_boff : cur_boff + OFFSET_BITS'(1);

        n_iq    = cur_iq;
        n_qp    = cur_qp;
        n_afs   = cur_afs;
        n_row   = cur_row;
        n_col   = cur_col;
        n_boff  = next_start;
        n_foff  = cur_foff;
        n_roff  = cur_roff;
        cls     = csvft_pkg::CLASS_CONTENT;
        content = '0;

        // A pending quote followed by anything but a quote closed the quoted span.
        if (cur_qp && !i_tok.is_quote) begin
            n_iq = 1'b0;
            n_qp = 1'b0;
        end

        if (!n_iq && i_tok.is_newline) begin
            cls    = csvft_pkg::CLASS_RECORD_END;
            n_row  = (cur_row == '1) ? cur_row : cur_row + ROW_BITS'(1);
            n_col  = '0;
            n_roff = next_start;
            n_foff = next_start;
            n_afs  = 1'b1;
        end else if (!n_iq && cur_afs && i_tok.is_quote) begin
            cls   = csvft_pkg::CLASS_QUOTE;
            n_iq  = 1'b1;
            n_afs = 1'b0;
        end else if (n_iq && i_tok.is_quote) begin
            if (cur_qp) begin
                cls     = csvft_pkg::CLASS_CONTENT;
                content = i_tok.byte_in;
                n_qp    = 1'b0;
            end else begin
                cls  = csvft_pkg::CLASS_QUOTE;
                n_qp = 1'b1;
            end
        end else if (!n_iq && i_tok.is_sep) begin
            cls    = csvft_pkg::CLASS_FIELD_END;
            n_col  = (cur_col == '1) ? cur_col : cur_col + COLUMN_BITS'(1);
            n_foff = next_start;
            n_afs  = 1'b1;
        end else begin
            cls     = csvft_pkg::CLASS_CONTENT;
            content = i_tok.byte_in;
            n_afs   = 1'b0;
        end

        hit = (cls == csvft_pkg::CLASS_CONTENT) && (cur_row == i_target_row) &&
              (cur_col == i_target_column);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq        <= 1'b0;
            r_qp        <= 1'b0;
            r_afs       <= 1'b1;
            r_row       <= '0;
            r_col       <= '0;
            r_boff      <= '0;
            r_foff      <= '0;
            r_roff      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_tok_pop) begin
                r_iq   <= n_iq;
                r_qp   <= n_qp;
                r_afs  <= n_afs;
                r_row  <= n_row;
                r_col  <= n_col;
                r_boff <= n_boff;
                r_foff <= n_foff;
                r_roff <= n_roff;
                r_out_valid <= 1'b1;
            end else if (o_token.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop) begin
            r_class   <= cls;
            r_content <= content;
            r_row_out <= cur_row;
            r_col_out <= cur_col;
            r_fs_out  <= cur_foff;
            r_rs_out  <= cur_roff;
            r_hit     <= hit;
        end
    end

    assign o_token.valid           = r_out_valid;
    assign o_token.byte_class      = r_class;
    assign o_token.content_byte    = r_content;
    assign o_token.row_index       = r_row_out;
    assign o_token.column_index    = r_col_out;
    assign o_token.field_start     = r_fs_out;
    assign o_token.record_start    = r_rs_out;
    assign o_token.in_target_field = r_hit;

`ifndef SYNTHESIS
    a_pending_needs_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qp |-> r_iq)
        else $error("Quote pending while outside quotes.");

    a_field_start_unquoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_afs |-> !r_iq)
        else $error("Field start flagged inside quotes.");

    a_field_after_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_foff >= r_roff)
        else $error("Field offset lies before record offset.");

    a_content_only_in_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_class != csvft_pkg::CLASS_CONTENT) |-> (r_content == '0 && !r_hit))
        else $error("Content or target flag on a non-content result.");
`endif

endmodule

>>> sim/csvft_token_checker.sv
// Checker that predicts every tokenizer result and compares it with the result channel.
`timescale 1ns / 1ps
module csvft_token_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    csvft_byte_if  i_byte,
    csvft_cfg_if   i_cfg,
    csvft_token_if i_token,
    output int     o_fail_count,
    output int     o_outstanding
);

    localparam int ROW_BITS    = csvft_pkg::DEF_ROW_BITS;
    localparam int COLUMN_BITS = csvft_pkg::DEF_COLUMN_BITS;
    localparam int OFFSET_BITS = csvft_pkg::DEF_OFFSET_BITS;

    typedef struct packed {
        csvft_pkg::t_class      cls;
        logic [7:0]             content;
        logic [ROW_BITS-1:0]    row;
        logic [COLUMN_BITS-1:0] column;
        logic [OFFSET_BITS-1:0] field_start;
        logic [OFFSET_BITS-1:0] record_start;
        logic                   in_target;
    } t_token;

    t_token expected_tokens[$];

    logic [7:0]             sep_reg;
    logic [7:0]             quote_reg;
    logic [ROW_BITS-1:0]    target_row_reg;
    logic [COLUMN_BITS-1:0] target_column_reg;

    logic                   quoted;
    logic                   quote_seen;
    logic                   field_fresh;
    logic [ROW_BITS-1:0]    row_cnt;
    logic [COLUMN_BITS-1:0] column_cnt;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] field_ofs;
    logic [OFFSET_BITS-1:0] record_ofs;

    function automatic void restart_text();
        quoted      = 1'b0;
        quote_seen  = 1'b0;
        field_fresh = 1'b1;
        row_cnt     = '0;
        column_cnt  = '0;
        offset      = '0;
        field_ofs   = '0;
        record_ofs  = '0;
    endfunction

    function automatic t_token tokenize_byte(input logic [7:0] b, input logic sot);
        t_token                 t;
        logic [OFFSET_BITS-1:0] next_start;
        if (sot) begin
            restart_text();
        end
        t.content      = '0;
        t.row          = row_cnt;
        t.column       = column_cnt;
        t.field_start  = field_ofs;
        t.record_start = record_ofs;
        next_start     = (offset == '1) ? offset : offset + 1'b1;
        if (quote_seen && b != quote_reg) begin
            quoted     = 1'b0;
            quote_seen = 1'b0;
        end
        if (!quoted && b == csvft_pkg::NEWLINE_CHAR) begin
            t.cls       = csvft_pkg::CLASS_RECORD_END;
            row_cnt     = (row_cnt == '1) ? row_cnt : row_cnt + 1'b1;
            column_cnt  = '0;
            record_ofs  = next_start;
            field_ofs   = next_start;
            field_fresh = 1'b1;
        end else if (!quoted && field_fresh && b == quote_reg) begin
            t.cls       = csvft_pkg::CLASS_QUOTE;
            quoted      = 1'b1;
            field_fresh = 1'b0;
        end else if (quoted && b == quote_reg) begin
            if (quote_seen) begin
                t.cls      = csvft_pkg::CLASS_CONTENT;
                t.content  = b;
                quote_seen = 1'b0;
            end else begin
                t.cls      = csvft_pkg::CLASS_QUOTE;
                quote_seen = 1'b1;
            end
        end else if (!quoted && b == sep_reg) begin
            t.cls       = csvft_pkg::CLASS_FIELD_END;
            column_cnt  = (column_cnt == '1) ? column_cnt : column_cnt + 1'b1;
            field_ofs   = next_start;
            field_fresh = 1'b1;
        end else begin
            t.cls       = csvft_pkg::CLASS_CONTENT;
            t.content   = b;
            field_fresh = 1'b0;
        end
        offset      = next_start;
        t.in_target = (t.cls == csvft_pkg::CLASS_CONTENT) && (t.row == target_row_reg)
                      && (t.column == target_column_reg);
        return t;
    endfunction

    function automatic void show_token(input string tag, input t_token t);
        $display("  %s: class %0d byte %02h row %0d column %0d field %0d record %0d target %0b",
                 tag, t.cls, t.content, t.row, t.column, t.field_start, t.record_start,
                 t.in_target);
    endfunction

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            sep_reg           = csvft_pkg::SEPARATOR_RESET_VAL;
            quote_reg         = csvft_pkg::QUOTE_RESET_VAL;
            target_row_reg    = '0;
            target_column_reg = '0;
            restart_text();
            expected_tokens.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    csvft_pkg::REG_SEPARATOR:     sep_reg = i_cfg.data[7:0];
                    csvft_pkg::REG_QUOTE:         quote_reg = i_cfg.data[7:0];
                    csvft_pkg::REG_TARGET_ROW:    target_row_reg = i_cfg.data[ROW_BITS-1:0];
                    csvft_pkg::REG_TARGET_COLUMN:
                        target_column_reg = i_cfg.data[COLUMN_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_token.valid && i_token.ready) begin
                got.cls          = csvft_pkg::t_class'(i_token.byte_class);
                got.content      = i_token.content_byte;
                got.row          = i_token.row_index;
                got.column       = i_token.column_index;
                got.field_start  = i_token.field_start;
                got.record_start = i_token.record_start;
                got.in_target    = i_token.in_target_field;
                if (expected_tokens.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("Result transfer with no byte waiting at %0t:", $realtime);
                        show_token("got", got);
                    end
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("Result mismatch at %0t:", $realtime);
                            show_token("expected", want);
                            show_token("got", got);
                        end
                    end
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                expected_tokens.insert(expected_tokens.size(),
                                       tokenize_byte(i_byte.byte_in, i_byte.start_of_text));
            end
        end
        o_outstanding = expected_tokens.size();
    end

endmodule

>>> sim/tb_csv_field_tokenizer_unit.sv
// Testbench top for the CSV field tokenizer: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_csv_field_tokenizer_unit;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   fail_count;
    int   outstanding;
    int   items_sent = 0;
    int   cycle_count = 0;
    bit   steady = 1'b0;
    bit   sot_next = 1'b0;
    logic [7:0] cur_sep = csvft_pkg::SEPARATOR_RESET_VAL;
    logic [7:0] cur_quote = csvft_pkg::QUOTE_RESET_VAL;

    csvft_byte_if  byte_ch();
    csvft_cfg_if   cfg_ch();
    csvft_token_if token_ch();

    csv_field_tokenizer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_token (token_ch)
    );

    csvft_token_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (byte_ch),
        .i_cfg         (cfg_ch),
        .i_token       (token_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        token_ch.ready <= steady || ($urandom_range(99) >= 28);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value);
        while (!steady && $urandom_range(99) < 28) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.byte_in       <= value;
        byte_ch.start_of_text <= sot_next;
        sot_next = 1'b0;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [csvft_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] sep, input logic [7:0] quote,
                             input logic [23:0] row, input logic [15:0] column);
        wait_drained();
        write_reg(csvft_pkg::REG_SEPARATOR, {16'd0, sep});
        write_reg(csvft_pkg::REG_QUOTE, {16'd0, quote});
        write_reg(csvft_pkg::REG_TARGET_ROW, row);
        write_reg(csvft_pkg::REG_TARGET_COLUMN, {8'd0, column});
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        cur_sep   = sep;
        cur_quote = quote;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do v = 8'($urandom);
        while (v == cur_sep || v == cur_quote || v == csvft_pkg::NEWLINE_CHAR);
        return v;
    endfunction

    // Mostly well-formed records; unquoted fields now and then carry a stray quote.
    task automatic send_record();
        int fields;
        int len;
        fields   = $urandom_range(1, 4);
        sot_next = ($urandom_range(39) == 0);
        for (int f = 0; f < fields; f++) begin
            if (f != 0) send_byte(cur_sep);
            len = $urandom_range(0, 5);
            if ($urandom_range(1) == 1) begin
                send_byte(cur_quote);
                repeat (len) begin
                    case ($urandom_range(5))
                        0: begin
                            send_byte(cur_quote);
                            send_byte(cur_quote);
                        end
                        1: send_byte(cur_sep);
                        2: send_byte(csvft_pkg::NEWLINE_CHAR);
                        default: send_byte(plain_byte());
                    endcase
                end
                send_byte(cur_quote);
            end else begin
                repeat (len) send_byte(($urandom_range(9) == 0) ? cur_quote : plain_byte());
            end
        end
        send_byte(csvft_pkg::NEWLINE_CHAR);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            sot_next = ($urandom_range(49) == 0);
            case ($urandom_range(4))
                0: send_byte(cur_sep);
                1: send_byte(cur_quote);
                2: send_byte(csvft_pkg::NEWLINE_CHAR);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic run_phase(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(29) == 0) wait_drained();
            if ($urandom_range(4) == 0) send_noise();
            else send_record();
        end
    endtask

    initial begin
        string      directed_text;
        logic [7:0] shared_char;
        i_rst_n               = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.byte_in       = '0;
        byte_ch.start_of_text = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = csvft_pkg::REG_SEPARATOR;
        cfg_ch.data           = '0;
        token_ch.ready        = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_text = "x,\"a\"\",\n\",q\"\n,t\"\n\"\"\n";
        sot_next = 1'b1;
        for (int i = 0; i < directed_text.len(); i++) send_byte(directed_text[i]);
        send_byte(8'hFF);
        send_byte(8'h00);
        sot_next = 1'b1;
        send_byte("z");

        configure(",", "\"", 24'd1, 16'd1);
        run_phase(150);
        configure(";", "'", 24'd0, 16'd0);
        steady = 1'b1;
        run_phase(150);
        steady = 1'b0;
        configure(8'h00, 8'hFF, 24'hFFFFFF, 16'hFFFF);
        run_phase(100);
        shared_char = 8'($urandom);
        configure(shared_char, shared_char, 24'($urandom_range(2)), 16'($urandom_range(2)));
        run_phase(100);
        configure(csvft_pkg::NEWLINE_CHAR, "\"", 24'd2, 16'd0);
        run_phase(100);
        configure(",", csvft_pkg::NEWLINE_CHAR, 24'd0, 16'd1);
        run_phase(100);
        repeat (2) begin
            configure(8'($urandom), 8'($urandom), 24'($urandom_range(3)),
                      16'($urandom_range(3)));
            run_phase(150);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> csv_field_tokenizer_unit.f
sv/csvft_pkg.sv
sv/csvft_ifs.sv
sv/csvft_front.sv
sv/csvft_fifo.sv
sv/csvft_back.sv
sv/csv_field_tokenizer_unit.sv
sim/csvft_token_checker.sv
sim/tb_csv_field_tokenizer_unit.sv
